[sv/tccw_pkg.sv]
// Shared constants and widths for the text console cursor writer.
`timescale 1ns / 1ps
`default_nettype none
package tccw_pkg;

	localparam int COLUMNS      = 80;
	localparam int SCREEN_CELLS = 2000;
	localparam int TAB_SPACES   = 4;

	localparam int CHAR_W  = 7;
	localparam int CELL_W  = 11;
	localparam int VALUE_W = 16;
	localparam int ATTR_W  = 8;
	localparam int GLYPH_W = 8;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int TAB_CNT_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

	localparam logic [CHAR_W-1:0] CODE_NUL = 7'd0;
	localparam logic [CHAR_W-1:0] CODE_BS  = 7'd8;
	localparam logic [CHAR_W-1:0] CODE_TAB = 7'd9;
	localparam logic [CHAR_W-1:0] CODE_NL  = 7'd10;
	localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'd32;

endpackage
`default_nettype wire

[sv/tccw_if.sv]
// Valid/ready channel interfaces for characters in and cell results out.
`timescale 1ns / 1ps
`default_nettype none
interface tccw_char_if
	import tccw_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface tccw_result_if
	import tccw_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               cell_write;
	logic [CELL_W-1:0]  cell_address;
	logic [VALUE_W-1:0] cell_value;
	logic               scroll_up;
	logic [CELL_W-1:0]  cursor_position;
	logic               last;

	modport source (output valid, output cell_write, output cell_address, output cell_value,
		output scroll_up, output cursor_position, output last, input ready);
	modport sink (input valid, input cell_write, input cell_address, input cell_value,
		input scroll_up, input cursor_position, input last, output ready);
endinterface
`default_nettype wire

[sv/text_console_cursor_writer_top.sv]
// Text console cursor writer: character items in, screen cell write items out.
//
// chars:   sink channel, one 7-bit character per item (valid/ready).
// results: source channel, one cell write / cursor update per item (valid/ready).
// text_attribute_we/_wdata: writes the attribute byte used in every written cell value.
//
// A character is taken into an input register; from there the result is
// computed from the cursor and column registers and loaded into the result
// register, which offers it on the results channel.
// Printable characters, newline and backspace give one result each and a new
// character is taken every cycle unless the receiver stalls. A tab gives one
// result per space while holding the input register. Code zero gives no result.
// Reaching the end of the screen flags scroll_up and puts the cursor at the
// start of the last line; the scroll copy is up to the receiver.
//
// Reset puts the cursor at cell 0 and the attribute at 2, and empties both
// registers. When the receiver stalls, the pending result is held and the input
// register keeps one more character, after which chars.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_writer_top
	import tccw_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	tccw_char_if.sink          chars,
	tccw_result_if.source      results,
	input  wire                text_attribute_we,
	input  wire [ATTR_W-1:0]   text_attribute_wdata
);

	logic [ATTR_W-1:0]    attr_q;
	logic [CELL_W-1:0]    cursor_q;
	logic [COL_W-1:0]     col_q;

	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic [TAB_CNT_W-1:0] tab_cnt_s1;

	logic                 res_valid_q;
	logic                 res_write_q;
	logic [CELL_W-1:0]    res_addr_q;
	logic [VALUE_W-1:0]   res_value_q;
	logic                 res_scroll_q;
	logic [CELL_W-1:0]    res_cursor_q;
	logic                 res_last_q;

	logic                 is_nul;
	logic                 out_free;
	logic                 step;
	logic                 done;

	logic                 nx_write;
	logic [CELL_W-1:0]    nx_addr;
	logic [VALUE_W-1:0]   nx_value;
	logic                 nx_scroll;
	logic [CELL_W-1:0]    nx_cursor;
	logic [COL_W-1:0]     nx_col;
	logic                 nx_last;
	logic [CELL_W:0]      adv_cell;
	logic [GLYPH_W-1:0]   glyph;

	assign is_nul   = (char_s1 == CODE_NUL);
	assign out_free = !res_valid_q || results.ready;
	assign step     = valid_s1 && !is_nul && out_free;
	assign done     = valid_s1 && (is_nul || (out_free && nx_last));
	assign chars.ready = !valid_s1 || done;

	always_comb begin
		nx_write  = 1'b1;
		nx_addr   = cursor_q;
		nx_scroll = 1'b0;
		nx_cursor = cursor_q;
		nx_col    = col_q;
		nx_last   = 1'b1;
		glyph     = {1'b0, char_s1};
		adv_cell  = {1'b0, cursor_q} + (CELL_W+1)'(1);
		if (char_s1 == CODE_NL) begin
			nx_write = 1'b0;
			nx_addr  = '0;
			adv_cell = {1'b0, cursor_q} + (CELL_W+1)'(COLUMNS) - (CELL_W+1)'(col_q);
			nx_col   = '0;
		end else if (char_s1 == CODE_BS && cursor_q != '0) begin
			adv_cell = {1'b0, cursor_q} - (CELL_W+1)'(1);
			nx_addr  = adv_cell[CELL_W-1:0];
			glyph    = GLYPH_SPACE;
			nx_col   = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
		end else begin
			if (char_s1 == CODE_TAB) begin
				glyph   = GLYPH_SPACE;
				nx_last = (tab_cnt_s1 == TAB_CNT_W'(TAB_SPACES - 1));
			end
			nx_col = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
		end
		nx_value = nx_write ? {attr_q, glyph} : '0;
		// off the bottom of the screen: scroll and restart on the last line
		if (adv_cell >= (CELL_W+1)'(SCREEN_CELLS)) begin
			nx_scroll = 1'b1;
			nx_cursor = CELL_W'(SCREEN_CELLS - COLUMNS);
			nx_col    = '0;
		end else begin
			nx_cursor = adv_cell[CELL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_W'(2);
		end else if (text_attribute_we) begin
			attr_q <= text_attribute_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			tab_cnt_s1 <= '0;
			cursor_q   <= '0;
			col_q      <= '0;
		end else begin
			if (chars.valid && chars.ready) begin
				valid_s1   <= 1'b1;
				tab_cnt_s1 <= '0;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (step) begin
				tab_cnt_s1 <= tab_cnt_s1 + TAB_CNT_W'(1);
			end
			if (step) begin
				cursor_q <= nx_cursor;
				col_q    <= nx_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1 && !is_nul;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_write_q  <= nx_write;
			res_addr_q   <= nx_addr;
			res_value_q  <= nx_value;
			res_scroll_q <= nx_scroll;
			res_cursor_q <= nx_cursor;
			res_last_q   <= nx_last;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.cell_write      = res_write_q;
	assign results.cell_address    = res_addr_q;
	assign results.cell_value      = res_value_q;
	assign results.scroll_up       = res_scroll_q;
	assign results.cursor_position = res_cursor_q;
	assign results.last            = res_last_q;

endmodule
`default_nettype wire
